@@ src/segment_intersection_point_core_macros.svh @@
// assertion macros for the segment intersection core
// no dependencies
`ifndef SEGMENT_INTERSECTION_POINT_CORE_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define SIP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SIP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/sip_pkg.sv @@
// shared constants for the segment intersection core
// no dependencies
`timescale 1ns / 1ps
package sip_pkg;
  localparam int unsigned CoordWidth = 16;
endpackage

@@ src/sip_div.sv @@
// pipelined restoring divider, one quotient bit per stage
// depends on sip_pkg
`timescale 1ns / 1ps
module sip_div import sip_pkg::*; #(
  parameter int unsigned NW = 2 * CoordWidth + 3,
  parameter int unsigned DW = 2 * CoordWidth + 3,
  parameter int unsigned QW = CoordWidth + 1,
  parameter int unsigned TW = 2 * CoordWidth + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          valid_o,
  output logic [QW-1:0] quot_o,
  output logic [TW-1:0] tag_o
);
  // quotient fits QW bits, so the top NW-QW bits seed the remainder
  localparam int unsigned RW = DW + 1;
  logic [QW:0]          v_q;
  logic [RW-1:0]        rem_q [QW+1];
  logic [NW-1:0]        num_q [QW+1];
  logic [DW-1:0]        den_q [QW+1];
  logic [QW-1:0]        quo_q [QW+1];
  logic [TW-1:0]        tag_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[QW-1:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= RW'(num_i >> QW);
    num_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    tag_q[0] <= tag_i;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW-1:0] sh;
    logic [RW:0]   diff;
    always_comb begin
      sh   = {rem_q[s][RW-2:0], num_q[s][QW-1-s]};
      diff = {1'b0, sh} - {2'b0, den_q[s]};
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= diff[RW] ? sh : diff[RW-1:0];
      quo_q[s+1] <= {quo_q[s][QW-2:0], ~diff[RW]};
      num_q[s+1] <= num_q[s];
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
    end
  end

  assign valid_o = v_q[QW];
  assign quot_o  = quo_q[QW];
  assign tag_o   = tag_q[QW];
endmodule

@@ src/segment_intersection_point_core.sv @@
// segment intersection core, top level
// depends on sip_pkg, sip_div and the macro header
//
// channel  dir  handshake               payload
// cmd      in   start & !busy           a1..b2 x/z, height_in_i
// result   out  strobe_o, one cycle     hit_o, hit_x_o, hit_z_o, hit_height_o
//
// one item per cycle; path from the accepting edge: five front
// stages, COORD_WIDTH + 2 divider registers (one quotient bit a stage, both axes side by
// side) and the output register
// busy is always low: the receiver cannot stall, so nothing ever backs up
// reset clears the valid bits only; payload registers are not reset
`timescale 1ns / 1ps
`include "segment_intersection_point_core_macros.svh"
module segment_intersection_point_core import sip_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] a1_x_i,
  input  logic signed [COORD_WIDTH-1:0] a1_z_i,
  input  logic signed [COORD_WIDTH-1:0] a2_x_i,
  input  logic signed [COORD_WIDTH-1:0] a2_z_i,
  input  logic signed [COORD_WIDTH-1:0] b1_x_i,
  input  logic signed [COORD_WIDTH-1:0] b1_z_i,
  input  logic signed [COORD_WIDTH-1:0] b2_x_i,
  input  logic signed [COORD_WIDTH-1:0] b2_z_i,
  input  logic signed [COORD_WIDTH-1:0] height_in_i,
  output logic                          strobe_o,
  output logic                          hit_o,
  output logic signed [COORD_WIDTH-1:0] hit_x_o,
  output logic signed [COORD_WIDTH-1:0] hit_height_o,
  output logic signed [COORD_WIDTH-1:0] hit_z_o
);
  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned DW = W + 1;          // differences
  localparam int unsigned PW = 2 * W + 3;      // perp products
  localparam int unsigned QW = W + 1;          // quotient magnitude
  localparam int unsigned TW = 2 * W + 2;      // x tag: hit, sign, start, height
  localparam int unsigned TZ = W + 1;          // z tag: sign, start
  localparam int unsigned NW = W + PW;         // |delta| * |f-p|

  assign busy = 1'b0;
  logic acc;
  assign acc = start && !busy;

  // stage 1: differences
  logic v1_q;
  logic signed [DW-1:0] ax_q, az_q, bx_q, bz_q, cx_q, cz_q;
  logic signed [W-1:0]  b1x_1q, b1z_1q, h1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= acc;
  end
  always_ff @(posedge clk_i) begin
    ax_q <= DW'(a2_x_i) - DW'(a1_x_i);
    az_q <= DW'(a2_z_i) - DW'(a1_z_i);
    bx_q <= DW'(b2_x_i) - DW'(b1_x_i);
    bz_q <= DW'(b2_z_i) - DW'(b1_z_i);
    cx_q <= DW'(b2_x_i) - DW'(a2_x_i);
    cz_q <= DW'(b2_z_i) - DW'(a2_z_i);
    b1x_1q <= b1_x_i;
    b1z_1q <= b1_z_i;
    h1_q <= height_in_i;
  end

  // stage 2: six products
  logic v2_q;
  logic signed [2*DW-1:0] m_q [6];
  logic signed [DW-1:0]   bx2_q, bz2_q;
  logic signed [W-1:0]    b1x_2q, b1z_2q, h2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    m_q[0] <= az_q * bx_q;
    m_q[1] <= ax_q * bz_q;
    m_q[2] <= az_q * cx_q;
    m_q[3] <= ax_q * cz_q;
    m_q[4] <= bz_q * cx_q;
    m_q[5] <= bx_q * cz_q;
    bx2_q <= bx_q; bz2_q <= bz_q;
    b1x_2q <= b1x_1q; b1z_2q <= b1z_1q; h2_q <= h1_q;
  end

  // stage 3: perp products
  logic v3_q;
  logic signed [PW-1:0] f_q, p_q, q_q;
  logic signed [DW-1:0] bx3_q, bz3_q;
  logic signed [W-1:0]  b1x_3q, b1z_3q, h3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    f_q <= PW'(m_q[0]) - PW'(m_q[1]);
    p_q <= PW'(m_q[2]) - PW'(m_q[3]);
    q_q <= PW'(m_q[4]) - PW'(m_q[5]);
    bx3_q <= bx2_q; bz3_q <= bz2_q;
    b1x_3q <= b1x_2q; b1z_3q <= b1z_2q; h3_q <= h2_q;
  end

  // stage 4: hit test, magnitudes
  logic hit_c;
  always_comb begin
    if (f_q == '0) hit_c = 1'b0;
    else if (f_q[PW-1])
      hit_c = (p_q <= 0) && (q_q <= 0) && (p_q >= f_q) && (q_q >= f_q);
    else
      hit_c = (p_q >= 0) && (q_q >= 0) && (p_q <= f_q) && (q_q <= f_q);
  end
  logic v4_q, hit4_q;
  logic [PW-1:0] an_q, ad_q;
  logic [DW-1:0] mbx_q, mbz_q;
  logic          sbx_q, sbz_q;
  logic signed [W-1:0] b1x_4q, b1z_4q, h4_q;
  logic signed [PW-1:0] num_c;
  assign num_c = f_q - p_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else v4_q <= v3_q;
  end
  always_ff @(posedge clk_i) begin
    hit4_q <= hit_c;
    an_q <= num_c[PW-1] ? PW'(-num_c) : PW'(num_c);
    ad_q <= f_q[PW-1] ? PW'(-f_q) : PW'(f_q);
    mbx_q <= bx3_q[DW-1] ? DW'(-bx3_q) : DW'(bx3_q);
    mbz_q <= bz3_q[DW-1] ? DW'(-bz3_q) : DW'(bz3_q);
    sbx_q <= bx3_q[DW-1]; sbz_q <= bz3_q[DW-1];
    b1x_4q <= b1x_3q; b1z_4q <= b1z_3q; h4_q <= h3_q;
  end

  // stage 5: numerators, the b difference magnitude fits W bits so the product fits W+PW bits
  logic v5_q, hit5_q;
  logic [NW-1:0] nx_q, nz_q;
  logic [PW-1:0] ad5_q;
  logic          sbx5_q, sbz5_q;
  logic signed [W-1:0] b1x_5q, b1z_5q, h5_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else v5_q <= v4_q;
  end
  always_ff @(posedge clk_i) begin
    nx_q <= NW'(mbx_q * an_q);
    nz_q <= NW'(mbz_q * an_q);
    ad5_q <= ad_q; hit5_q <= hit4_q;
    sbx5_q <= sbx_q; sbz5_q <= sbz_q;
    b1x_5q <= b1x_4q; b1z_5q <= b1z_4q; h5_q <= h4_q;
  end

  // divider lanes; height rides with the x lane tag, the z lane carries nothing extra
  logic          dvx, dvz;
  logic [QW-1:0] qx, qz;
  logic [TW-1:0] tgx;
  logic [TZ-1:0] tgz;
  sip_div #(.NW(NW), .DW(PW), .QW(QW), .TW(TW)) u_div_x (
    .clk_i, .rst_ni, .valid_i(v5_q), .num_i(nx_q), .den_i(ad5_q),
    .tag_i({hit5_q, sbx5_q, b1x_5q, h5_q}),
    .valid_o(dvx), .quot_o(qx), .tag_o(tgx));
  sip_div #(.NW(NW), .DW(PW), .QW(QW), .TW(TZ)) u_div_z (
    .clk_i, .rst_ni, .valid_i(v5_q), .num_i(nz_q), .den_i(ad5_q),
    .tag_i({sbz5_q, b1z_5q}),
    .valid_o(dvz), .quot_o(qz), .tag_o(tgz));

  // output stage
  logic          hit_t, sx_t, sz_t;
  logic [W-1:0]  sxv, szv, hv;
  assign hit_t = tgx[TW-1];
  assign sx_t  = tgx[TW-2];
  assign sxv   = tgx[TW-3:W];
  assign hv    = tgx[W-1:0];
  assign sz_t  = tgz[TZ-1];
  assign szv   = tgz[W-1:0];
  logic str_q, hit_q;
  logic [W-1:0] hx_q, hz_q, hh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) str_q <= 1'b0;
    else str_q <= dvx;
  end
  always_ff @(posedge clk_i) begin
    hit_q <= hit_t;
    hh_q  <= hv;
    hx_q  <= hit_t ? (sx_t ? sxv - W'(qx) : sxv + W'(qx)) : '0;
    hz_q  <= hit_t ? (sz_t ? szv - W'(qz) : szv + W'(qz)) : '0;
  end
  assign strobe_o     = str_q;
  assign hit_o        = hit_q;
  assign hit_x_o      = hx_q;
  assign hit_z_o      = hz_q;
  assign hit_height_o = hh_q;

  `SIP_ASSERT_IMP(a_lanes_aligned, clk_i, rst_ni, 1'b1, dvx == dvz)
  `SIP_ASSERT_IMP(a_nohit_zero, clk_i, rst_ni, strobe_o && !hit_o,
                  hit_x_o == '0 && hit_z_o == '0)
  `SIP_ASSERT_NXT(a_strobe_follows, clk_i, rst_ni, dvx, strobe_o)
endmodule
